[rtl/core/meter_frame_receiver_assert.svh]
// ----------------------------------------------------------------------------
// Meter frame receiver assertion macros
// Concurrent assertion wrappers for the meter frame receiver.
// ----------------------------------------------------------------------------
`ifndef METER_FRAME_RECEIVER_ASSERT_SVH
`define METER_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MFR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("meter frame receiver check failed");

`define MFR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("meter frame receiver check failed");

`else

`define MFR_ASSERT(label, clk, rst, prop)

`define MFR_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[rtl/core/mfr_pkg.sv]
// ----------------------------------------------------------------------------
// Meter frame receiver package
// Shared constants and types of the meter frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfr_pkg;

   localparam int FRAME_BYTES = 24;
   localparam int IDX_W = 5;

   typedef logic [7:0] byte_type;
   typedef logic [IDX_W-1:0] idx_type;

   localparam byte_type SYNC_BYTE = 8'h5A;
   localparam idx_type SUM_FIRST = 5'd2;
   localparam idx_type SUM_LAST = 5'd22;
   localparam idx_type SUM_AT = 5'd23;
   localparam idx_type LAST_IDX = 5'd23;
   localparam idx_type FILL_AFTER_SHIFT = 5'd25;

   typedef struct packed {
      logic load;
      logic rotate;
   } cell_ctl_type;

   typedef struct packed {
      logic load;
      idx_type load_idx;
      logic rotate;
      byte_type data;
   } chain_ctl_type;

endpackage

[rtl/core/mfr_cell.sv]
// ----------------------------------------------------------------------------
// Meter frame receiver storage cell
// Holds one frame byte; loads a received word or takes its neighbor's byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfr_cell (
   input  logic                  clock,
   input  mfr_pkg::cell_ctl_type cell_ctl,
   input  mfr_pkg::byte_type     wr_byte,
   input  mfr_pkg::byte_type     nb_byte,
   output mfr_pkg::byte_type     cell_byte
);
   import mfr_pkg::*;

   byte_type byte_ff;
   byte_type byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (cell_ctl.load) begin
         byte_in = wr_byte;
      end else if (cell_ctl.rotate) begin
         byte_in = nb_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

[rtl/core/mfr_chain.sv]
// ----------------------------------------------------------------------------
// Meter frame receiver cell chain
// A ring of frame cells; each cell passes its byte to the one below it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfr_chain (
   input  logic                   clock,
   input  mfr_pkg::chain_ctl_type chain_ctl,
   output mfr_pkg::byte_type      cell_bytes [mfr_pkg::FRAME_BYTES]
);
   import mfr_pkg::*;

   for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_cell
      cell_ctl_type ctl;

      assign ctl.load = chain_ctl.load && (chain_ctl.load_idx == IDX_W'(k));
      assign ctl.rotate = chain_ctl.rotate;

      mfr_cell u_cell (
         .clock     (clock),
         .cell_ctl  (ctl),
         .wr_byte   (chain_ctl.data),
         .nb_byte   (cell_bytes[(k + 1) % FRAME_BYTES]),
         .cell_byte (cell_bytes[k])
      );
   end

endmodule

[rtl/core/meter_frame_receiver.sv]
// While the receiver is filling, each accepted word is written straight into a frame cell.
// After the last word of a frame, a checksum pass rotates the cell ring, summing bytes 2 to 22.
// A good frame then gives a result word, held back while a prior result waits on rsp_ready.
// A bad frame with a later sync byte at index p is rotated by p-1 places (1 to 22) to index 1.
// Throughput: one word per cycle while filling; req_ready is low in check, align and emit.
// Reset: synchronous, active high; clears control state, the frame cells are not cleared.
// ----------------------------------------------------------------------------
// Meter frame receiver
// Hunts for metering chip frames in a byte stream, verifies the checksum and
// returns the measurement fields of each good frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "meter_frame_receiver_assert.svh"

module meter_frame_receiver (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mfr_pkg::byte_type req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_header,
   output logic [23:0]       rsp_voltage_param,
   output logic [23:0]       rsp_voltage_cycle,
   output logic [23:0]       rsp_current_param,
   output logic [23:0]       rsp_current_cycle,
   output logic [23:0]       rsp_power_param,
   output logic [23:0]       rsp_power_cycle,
   output logic [7:0]        rsp_adjust_flags
);
   import mfr_pkg::*;

   localparam logic [1:0] ST_FILL  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_ALIGN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff, state_in;
   idx_type fill_ff, fill_in;
   logic in_frame_ff, in_frame_in;
   idx_type cnt_ff, cnt_in;
   byte_type sum_ff, sum_in;
   logic found_ff, found_in;
   idx_type pos_ff, pos_in;
   idx_type shift_ff, shift_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_load;

   byte_type head;
   logic pick;
   chain_ctl_type chain_ctl;
   byte_type cell_bytes [FRAME_BYTES];

   logic [7:0] header_ff;
   logic [23:0] voltage_param_ff, voltage_cycle_ff;
   logic [23:0] current_param_ff, current_cycle_ff;
   logic [23:0] power_param_ff, power_cycle_ff;
   logic [7:0] adjust_flags_ff;

   mfr_chain u_chain (
      .clock      (clock),
      .chain_ctl  (chain_ctl),
      .cell_bytes (cell_bytes)
   );

   assign head = cell_bytes[0];
   assign pick = (head == SYNC_BYTE) && !found_ff && (cnt_ff >= SUM_FIRST);

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      in_frame_in = in_frame_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      found_in = found_ff;
      pos_in = pos_ff;
      shift_in = shift_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_load = 1'b0;
      chain_ctl.load = 1'b0;
      chain_ctl.load_idx = fill_ff;
      chain_ctl.rotate = 1'b0;
      chain_ctl.data = req_rx_byte;

      unique case (state_ff)
         ST_FILL: begin
            if (req_valid) begin
               chain_ctl.load = 1'b1;
               if (!in_frame_ff) begin
                  if ((req_rx_byte == SYNC_BYTE) && (fill_ff == 5'd1)) begin
                     chain_ctl.load_idx = 5'd1;
                     fill_in = 5'd2;
                     in_frame_in = 1'b1;
                  end else begin
                     chain_ctl.load_idx = 5'd0;
                     fill_in = 5'd1;
                  end
               end else if (fill_ff == LAST_IDX) begin
                  state_in = ST_CHECK;
                  cnt_in = 5'd0;
                  sum_in = 8'd0;
                  found_in = 1'b0;
               end else begin
                  fill_in = fill_ff + 5'd1;
               end
            end
         end
         ST_CHECK: begin
            chain_ctl.rotate = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if ((cnt_ff >= SUM_FIRST) && (cnt_ff <= SUM_LAST)) begin
               sum_in = sum_ff + head;
            end
            if (pick) begin
               found_in = 1'b1;
               pos_in = cnt_ff;
            end
            if (cnt_ff == SUM_AT) begin
               if (sum_ff == head) begin
                  state_in = ST_EMIT;
               end else if (found_ff || pick) begin
                  state_in = ST_ALIGN;
                  shift_in = (found_ff ? pos_ff : cnt_ff) - 5'd1;
               end else begin
                  state_in = ST_FILL;
                  fill_in = 5'd0;
                  in_frame_in = 1'b0;
               end
            end
         end
         ST_ALIGN: begin
            chain_ctl.rotate = 1'b1;
            shift_in = shift_ff - 5'd1;
            if (shift_ff == 5'd1) begin
               state_in = ST_FILL;
               fill_in = FILL_AFTER_SHIFT - pos_ff;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_FILL;
               fill_in = 5'd0;
               in_frame_in = 1'b0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         fill_ff <= 5'd0;
         in_frame_ff <= 1'b0;
         cnt_ff <= 5'd0;
         sum_ff <= 8'd0;
         found_ff <= 1'b0;
         pos_ff <= 5'd0;
         shift_ff <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         in_frame_ff <= in_frame_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         found_ff <= found_in;
         pos_ff <= pos_in;
         shift_ff <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         header_ff <= cell_bytes[0];
         voltage_param_ff <= {cell_bytes[2], cell_bytes[3], cell_bytes[4]};
         voltage_cycle_ff <= {cell_bytes[5], cell_bytes[6], cell_bytes[7]};
         current_param_ff <= {cell_bytes[8], cell_bytes[9], cell_bytes[10]};
         current_cycle_ff <= {cell_bytes[11], cell_bytes[12], cell_bytes[13]};
         power_param_ff <= {cell_bytes[14], cell_bytes[15], cell_bytes[16]};
         power_cycle_ff <= {cell_bytes[17], cell_bytes[18], cell_bytes[19]};
         adjust_flags_ff <= cell_bytes[20];
      end
   end

   assign req_ready = (state_ff == ST_FILL);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_header = header_ff;
   assign rsp_voltage_param = voltage_param_ff;
   assign rsp_voltage_cycle = voltage_cycle_ff;
   assign rsp_current_param = current_param_ff;
   assign rsp_current_cycle = current_cycle_ff;
   assign rsp_power_param = power_param_ff;
   assign rsp_power_cycle = power_cycle_ff;
   assign rsp_adjust_flags = adjust_flags_ff;

   `MFR_ASSERT(a_frame_fill, clock, reset, (state_ff == ST_FILL && in_frame_ff) |-> (fill_ff >= 5'd2 && fill_ff <= LAST_IDX))
   `MFR_ASSERT(a_hunt_fill, clock, reset, (state_ff == ST_FILL && !in_frame_ff) |-> (fill_ff <= 5'd1))
   `MFR_ASSERT(a_align_shift, clock, reset, (state_ff == ST_ALIGN) |-> (pos_ff >= SUM_FIRST && pos_ff <= LAST_IDX && shift_ff != 5'd0 && shift_ff < pos_ff))
   `MFR_ASSERT(a_check_count, clock, reset, (state_ff == ST_CHECK && cnt_ff != SUM_AT) |=> (state_ff == ST_CHECK && cnt_ff == $past(cnt_ff) + 5'd1))
   `MFR_ASSERT(a_emit_source, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))

endmodule

[tb/sv/meter_frame_receiver_tb.sv]
// ----------------------------------------------------------------------------
// Meter frame receiver testbench
// Feeds serial bytes to the frame receiver: a few hand-built frames first,
// then a long random stream that is mostly well-formed frames, mixed with
// corrupted checksums, early sync bytes, truncated frames and line noise.
// A behavioral copy of the parser predicts each good frame, and every result
// word is compared field by field. Traffic runs under four pacing modes, with
// one long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module meter_frame_receiver_tb;

   import mfr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_WORDS = 295;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      byte_type    header;
      logic [23:0] voltage_param;
      logic [23:0] voltage_cycle;
      logic [23:0] current_param;
      logic [23:0] current_cycle;
      logic [23:0] power_param;
      logic [23:0] power_cycle;
      byte_type    adjust_flags;
   } meter_reading_type;

   typedef struct packed {
      logic [2:0]        noise_len;
      byte_type          noise;
      byte_type          header;
      byte_type          fill;
      logic [4:0]        sync_at;
      logic [4:0]        frame_len;
      byte_type          sum_flip;
      logic              typed;
      logic              has_result;
      meter_reading_type want;
   } frame_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   byte_type req_rx_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_header;
   logic [23:0] rsp_voltage_param;
   logic [23:0] rsp_voltage_cycle;
   logic [23:0] rsp_current_param;
   logic [23:0] rsp_current_cycle;
   logic [23:0] rsp_power_param;
   logic [23:0] rsp_power_cycle;
   logic [7:0] rsp_adjust_flags;

   byte_type frame_cells [FRAME_BYTES];
   int unsigned cells_filled = 0;
   bit synced = 1'b0;

   meter_reading_type readings_due [$];
   byte_type frame_buf [FRAME_BYTES];
   bit typed_rows_active = 1'b0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;
   int unsigned words_sent = 0;
   int unsigned frames_checked = 0;
   int unsigned failures = 0;
   int unsigned cycle_count = 0;

   meter_frame_receiver dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_header        (rsp_header),
      .rsp_voltage_param (rsp_voltage_param),
      .rsp_voltage_cycle (rsp_voltage_cycle),
      .rsp_current_param (rsp_current_param),
      .rsp_current_cycle (rsp_current_cycle),
      .rsp_power_param   (rsp_power_param),
      .rsp_power_cycle   (rsp_power_cycle),
      .rsp_adjust_flags  (rsp_adjust_flags)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= MAX_PRINTED) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
   endtask

   task automatic compare_field(input string name, input logic [23:0] got,
                                input logic [23:0] want);
      if (got !== want) begin
         note_failure($sformatf("%s is %h, expected %h", name, got, want));
      end
   endtask

   function automatic logic [23:0] cells_be24(input int at);
      return {frame_cells[at], frame_cells[at + 1], frame_cells[at + 2]};
   endfunction

   // Takes one byte into the parser copy; returns 1 when a good frame closes.
   function automatic bit absorb_byte(input byte_type value, output meter_reading_type reading);
      byte_type sum;
      int i;
      int j;
      int shift;
      reading = '0;
      if (!synced) begin
         if (value == SYNC_BYTE && cells_filled == 1) begin
            synced = 1'b1;
         end else begin
            cells_filled = 0;
         end
         frame_cells[cells_filled] = value;
         cells_filled++;
         return 1'b0;
      end
      frame_cells[cells_filled] = value;
      cells_filled++;
      if (cells_filled < FRAME_BYTES) begin
         return 1'b0;
      end
      sum = '0;
      for (i = SUM_FIRST; i <= SUM_LAST; i++) begin
         sum += frame_cells[i];
      end
      if (sum == frame_cells[SUM_AT]) begin
         reading.header = frame_cells[0];
         reading.voltage_param = cells_be24(2);
         reading.voltage_cycle = cells_be24(5);
         reading.current_param = cells_be24(8);
         reading.current_cycle = cells_be24(11);
         reading.power_param = cells_be24(14);
         reading.power_cycle = cells_be24(17);
         reading.adjust_flags = frame_cells[20];
         synced = 1'b0;
         cells_filled = 0;
         return 1'b1;
      end
      // A failed frame realigns on the next sync byte, which becomes index 1.
      for (i = 2; i < FRAME_BYTES; i++) begin
         if (frame_cells[i] == SYNC_BYTE) begin
            shift = i - 1;
            for (j = 0; j < FRAME_BYTES - shift; j++) begin
               frame_cells[j] = frame_cells[j + shift];
            end
            cells_filled = FRAME_BYTES - shift;
            return 1'b0;
         end
      end
      synced = 1'b0;
      cells_filled = 0;
      return 1'b0;
   endfunction

   function automatic byte_type payload_sum();
      byte_type s;
      int k;
      s = '0;
      for (k = SUM_FIRST; k <= SUM_LAST; k++) begin
         s += frame_buf[k];
      end
      return s;
   endfunction

   task automatic send_word(input byte_type value);
      meter_reading_type reading;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_rx_byte <= byte_type'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      words_sent++;
      if (absorb_byte(value, reading) && !typed_rows_active) begin
         readings_due.push_back(reading);
      end
   endtask

   task automatic send_frame(input int unsigned frame_len);
      int unsigned k;
      for (k = 0; k < frame_len; k++) begin
         send_word(frame_buf[k]);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (readings_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly good frames; the rest are bad checksums, early sync bytes,
   // truncated frames and short bursts of noise.
   task automatic send_random_piece();
      int unsigned pick;
      int unsigned k;
      int unsigned n;
      pick = $urandom_range(99);
      if (pick < 8) begin
         n = $urandom_range(4, 1);
         for (k = 0; k < n; k++) begin
            send_word(($urandom_range(3) == 0) ? SYNC_BYTE : byte_type'($urandom));
         end
         return;
      end
      frame_buf[0] = ($urandom_range(9) == 0) ? SYNC_BYTE : byte_type'($urandom);
      frame_buf[1] = SYNC_BYTE;
      for (k = SUM_FIRST; k <= SUM_LAST; k++) begin
         case ($urandom_range(15))
            0: frame_buf[k] = SYNC_BYTE;
            1: frame_buf[k] = 8'h00;
            2: frame_buf[k] = 8'hFF;
            default: frame_buf[k] = byte_type'($urandom);
         endcase
      end
      if (pick >= 70 && pick < 85 && $urandom_range(1) == 0) begin
         frame_buf[$urandom_range(SUM_LAST, SUM_FIRST)] = SYNC_BYTE;
      end
      frame_buf[SUM_AT] = payload_sum();
      if (pick >= 70 && pick < 85) begin
         if (frame_buf[SUM_AT] != SYNC_BYTE && $urandom_range(3) == 0) begin
            frame_buf[SUM_AT] = SYNC_BYTE;
         end else begin
            frame_buf[SUM_AT] ^= byte_type'($urandom_range(255, 1));
         end
      end
      send_frame((pick < 85) ? FRAME_BYTES : $urandom_range(FRAME_BYTES - 1, 2));
   endtask

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_asked;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      meter_reading_type got;
      meter_reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_header, rsp_voltage_param, rsp_voltage_cycle, rsp_current_param,
                rsp_current_cycle, rsp_power_param, rsp_power_cycle, rsp_adjust_flags};
         if (readings_due.size() == 0) begin
            note_failure("result word with no good frame pending");
         end else begin
            want = readings_due.pop_front();
            frames_checked++;
            compare_field("header", 24'(got.header), 24'(want.header));
            compare_field("voltage_param", got.voltage_param, want.voltage_param);
            compare_field("voltage_cycle", got.voltage_cycle, want.voltage_cycle);
            compare_field("current_param", got.current_param, want.current_param);
            compare_field("current_cycle", got.current_cycle, want.current_cycle);
            compare_field("power_param", got.power_param, want.power_param);
            compare_field("power_cycle", got.power_cycle, want.power_cycle);
            compare_field("adjust_flags", 24'(got.adjust_flags), 24'(want.adjust_flags));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      frame_row_type directed_rows [11];
      frame_row_type row;
      int r;
      int n;
      int phase;
      int unsigned phase_end;
      int unsigned pieces;

      // Columns: noise count, noise byte, header, payload fill, sync index,
      // bytes sent, checksum flip, typed, result, typed result.
      directed_rows = '{
         '{3'd0, 8'h00, 8'h00, 8'h00, 5'd0, 5'd24, 8'h00, 1'b1, 1'b1, '0},
         '{3'd0, 8'h00, 8'hFF, 8'hFF, 5'd0, 5'd24, 8'h00, 1'b1, 1'b1, '1},
         '{3'd0, 8'h00, 8'h00, 8'h11, 5'd0, 5'd24, 8'h01, 1'b1, 1'b0, '0},
         '{3'd0, 8'h00, 8'h5A, 8'h24, 5'd0, 5'd24, 8'h00, 1'b0, 1'b0, '0},
         '{3'd0, 8'h00, 8'h81, 8'h33, 5'd9, 5'd24, 8'h80, 1'b0, 1'b0, '0},
         '{3'd0, 8'h00, 8'h00, 8'h7E, 5'd0, 5'd24, 8'h00, 1'b0, 1'b0, '0},
         '{3'd3, 8'hC3, 8'h12, 8'hA5, 5'd0, 5'd24, 8'h00, 1'b0, 1'b0, '0},
         '{3'd0, 8'h00, 8'h44, 8'h01, 5'd0, 5'd10, 8'h00, 1'b0, 1'b0, '0},
         '{3'd0, 8'h00, 8'h99, 8'h5B, 5'd0, 5'd24, 8'h00, 1'b0, 1'b0, '0},
         '{3'd0, 8'h00, 8'h66, 8'hC0, 5'd2, 5'd24, 8'h55, 1'b0, 1'b0, '0},
         '{3'd0, 8'h00, 8'h0F, 8'hF0, 5'd0, 5'd24, 8'h00, 1'b0, 1'b0, '0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < 11; r++) begin
         row = directed_rows[r];
         for (n = 0; n < row.noise_len; n++) begin
            send_word(row.noise);
         end
         frame_buf[0] = row.header;
         frame_buf[1] = SYNC_BYTE;
         for (n = SUM_FIRST; n <= SUM_LAST; n++) begin
            frame_buf[n] = row.fill;
         end
         if (row.sync_at != 0) begin
            frame_buf[row.sync_at] = SYNC_BYTE;
         end
         frame_buf[SUM_AT] = payload_sum() ^ row.sum_flip;
         typed_rows_active = row.typed;
         send_frame(row.frame_len);
         typed_rows_active = 1'b0;
         if (row.typed && row.has_result) begin
            readings_due.push_back(row.want);
         end
      end
      wait_drained();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 85;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct <= 85;
            end
            default: begin
               send_idle_pct = 28;
               stall_pct <= 28;
            end
         endcase
         phase_end = words_sent + PHASE_WORDS;
         pieces = 0;
         while (words_sent < phase_end) begin
            send_random_piece();
            pieces++;
            if (phase == 0 && pieces == 3) begin
               holds_asked <= holds_asked + 1;
            end
         end
         wait_drained();
      end

      if (readings_due.size() != 0) begin
         note_failure($sformatf("%0d good frames never produced a result",
                                readings_due.size()));
      end
      $display("Run summary: %0d bytes sent through directed frames and four pacing modes,",
               words_sent);
      $display("%0d frame results checked, including one long receiver hold-off.",
               frames_checked);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
